// ----- design/sle_pkg.sv -----
// shared constants, codes and command type of the sequential list engine
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FIDX_W = 7;
  localparam int unsigned LEN_W  = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // command broadcast from the control to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             load;
    logic             shift;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } sle_cmd_t;

endpackage

// ----- design/sle_cell.sv -----
// one list slot: entry register plus match flag, shifting with its neighbors
module sle_cell #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int unsigned IDX      = 0
) (
  input  logic                                clk,
  input  sle_pkg::sle_cmd_t                   cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]       count,
  input  logic [sle_pkg::VAL_W-1:0]           left_entry,
  input  logic [sle_pkg::VAL_W-1:0]           right_entry,
  input  logic                                right_flag,
  output logic [sle_pkg::VAL_W-1:0]           entry,
  output logic                                flag
);
  import sle_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CW-1:0]    SLOT      = CW'(IDX);
  localparam logic [CW-1:0]    SLOT_NEXT = CW'(IDX + 1);
  localparam logic [CNT_W-1:0] SLOT_CNT  = CNT_W'(IDX);

  logic [VAL_W-1:0] entry_r, entry_nxt;
  logic             flag_r, flag_nxt;
  logic [CW-1:0]    pos_x;

  assign pos_x = CW'(cmd.pos);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (SLOT == pos_x) begin
        entry_nxt = cmd.value;
      end else if (SLOT > pos_x) begin
        entry_nxt = left_entry;
      end
    end else if (cmd.del && (SLOT_NEXT >= pos_x)) begin
      entry_nxt = right_entry;
    end
  end

  // flag marks a live slot that matches the searched value
  always_comb begin
    flag_nxt = flag_r;
    if (cmd.load) begin
      flag_nxt = (entry_r == cmd.value) && (SLOT_CNT < count);
    end else if (cmd.shift) begin
      flag_nxt = right_flag;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    flag_r  <= flag_nxt;
  end

  assign entry = entry_r;
  assign flag  = flag_r;

endmodule

// ----- design/sle_chain.sv -----
// row of list cells, entries move up on insert and down on delete
module sle_chain #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  sle_pkg::sle_cmd_t             cmd,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  output logic                          first_flag,
  output logic                          any_flag
);
  import sle_pkg::*;

  logic [VAL_W-1:0]    ent [CAPACITY];
  logic [CAPACITY-1:0] flags;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VAL_W-1:0] left_e, right_e;
    logic             right_f;

    if (k == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_body
      assign left_e = ent[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
      assign right_f = 1'b0;
    end else begin : g_mid
      assign right_e = ent[k+1];
      assign right_f = flags[k+1];
    end

    sle_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (k)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .left_entry  (left_e),
      .right_entry (right_e),
      .right_flag  (right_f),
      .entry       (ent[k]),
      .flag        (flags[k])
    );
  end

  assign first_flag = flags[0];
  assign any_flag   = |flags;

endmodule

// ----- design/sequential_list_engine_core.sv -----
// top level of the sequential list engine: control, length count and result register
//
// The list lives in a row of CAPACITY cells, one entry per cell, kept in order
// with a length count that reset sets to zero. On insert the cell at the position
// takes the new value and every cell after it takes its left neighbor's entry; on
// delete every cell from the position minus one on takes its right neighbor's
// entry, all in the same clock. An insert or delete result appears in the output
// register in the cycle after the input transaction, and a new item may follow in
// the very next cycle unless that result waits on out_stall. Find is done in two
// parts: at acceptance every live cell compares its entry to the value and
// latches a match flag, then the flags shift toward cell zero one place per clock
// until the lowest match reaches it. While a find is scanning, no new item is
// taken. A result that waits on out_stall holds in the output register and blocks
// further input until it is taken. Refused operations (full list, bad position,
// reserved operation code) leave the list unchanged and answer with their status.
module sequential_list_engine_core #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sle_pkg::OP_W-1:0]   in_operation,
  input  logic signed [sle_pkg::VAL_W-1:0] in_value,
  input  logic [sle_pkg::POS_W-1:0]  in_position,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sle_pkg::STAT_W-1:0] out_status,
  output logic [sle_pkg::FIDX_W-1:0] out_found_index,
  output logic [sle_pkg::LEN_W-1:0]  out_length
);
  import sle_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned PX_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned FX_W  = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
  localparam int unsigned LX_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // control states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [FIDX_W-1:0] out_found_r, out_found_nxt;
  logic [LEN_W-1:0]  out_length_r, out_length_nxt;

  sle_cmd_t          cmd;
  logic              first_flag, any_flag;
  logic              in_acc, out_free;
  logic              res_valid;
  logic [STAT_W-1:0] res_status;
  logic [FIDX_W-1:0] res_found;
  logic [PX_W-1:0]   pos_x, cnt_x;
  logic [FX_W-1:0]   idx_x;
  logic [LX_W-1:0]   len_x;

  // output register may be written when empty or emptied this cycle
  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = (state_r == S_SCAN) | ~out_free;
  assign in_acc   = in_valid & ~in_stall;

  assign pos_x = PX_W'(in_position);
  assign cnt_x = PX_W'(count_r);
  assign idx_x = FX_W'(idx_r);

  always_comb begin
    cmd        = '0;
    cmd.value  = in_value;
    cmd.pos    = in_position;
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_found  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_operation)
            OP_FIND: begin
              // latch match flags in every live cell, then scan
              cmd.load  = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
            OP_INSERT: begin
              res_valid = 1'b1;
              if (count_r == CNT_FULL) begin
                res_status = ST_FULL;
              end else if (pos_x > cnt_x) begin
                res_status = ST_BADPOS;
              end else begin
                cmd.ins   = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DELETE: begin
              res_valid = 1'b1;
              if ((in_position == '0) || (pos_x > cnt_x)) begin
                res_status = ST_BADPOS;
              end else begin
                cmd.del   = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              // reserved operation code
              res_valid  = 1'b1;
              res_status = ST_BADPOS;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!any_flag) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res_status = ST_NOTFOUND;
            state_nxt  = S_IDLE;
          end
        end else if (first_flag) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res_status = ST_OK;
            res_found  = idx_x[FIDX_W-1:0];
            state_nxt  = S_IDLE;
          end
        end else begin
          // move flags one cell toward the head
          cmd.shift = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign len_x = LX_W'(count_nxt);

  always_comb begin
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_length_nxt = out_length_r;
    if (res_valid) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_found_nxt  = res_found;
      out_length_nxt = len_x[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_length_r <= out_length_nxt;
  end

  sle_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk        (clk),
    .cmd        (cmd),
    .count      (count_r),
    .first_flag (first_flag),
    .any_flag   (any_flag)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_length      = out_length_r;

  // length never runs past the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("list length beyond capacity");

  // a scan never changes the list length
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (count_r == $past(count_r)))
    else $error("length changed during find");

  // accepted insert that succeeds grows the list by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow list");

  // exhausted scan reports not found
  a_scan_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && !any_flag && out_free)
      |=> (out_valid_r && (out_status_r == ST_NOTFOUND) && (state_r == S_IDLE)))
    else $error("missed find not reported");

  // no flag shift ever happens outside a scan
  a_shift_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> ((state_r == S_SCAN) && any_flag && !first_flag))
    else $error("flag shift outside scan");

endmodule
